>>> hdl/rxs_pkg.sv
// Package for the record exchange sort block.
// Holds the record type, the capacity default and the controller/datapath command
// and status structs. It depends on nothing.
package rxs_pkg;

  localparam int RXS_MAX_RECORDS = 64;
  localparam int RXS_KEY_W       = 16;
  localparam int RXS_TAG_W       = 16;

  typedef struct packed {
    logic [RXS_KEY_W-1:0] key;
    logic [RXS_TAG_W-1:0] tag;
  } rec_t;

  localparam int RXS_REC_W = $bits(rec_t);

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // store the accepted record or flag overflow
    logic clr_set;    // empty the store after the final result
    logic init_sort;  // outer index to zero
    logic rd_i;       // read entry i, inner index to i+1
    logic cap_held;   // capture read data as the held record
    logic rd_j;       // read entry j
    logic cmp_j;      // compare and swap with entry j, advance j
    logic wr_i;       // write held record to entry i, advance i
    logic init_emit;  // output index to zero
    logic rd_k;       // read entry k
    logic ld_out;     // load output register, advance k
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic n_lt2;
    logic j_last;
    logic i_last;
    logic k_last;
    logic out_free;
  } sts_t;

endpackage

>>> hdl/rxs_if.sv
// Valid/ready channel interfaces for the record exchange sort block.
// Depends on rxs_pkg for the field widths.
interface rxs_in_if;
  import rxs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RXS_KEY_W-1:0] quantity;
  logic [RXS_TAG_W-1:0] record_tag;
  logic                 is_last;

  modport source (output valid, output quantity, output record_tag, output is_last,
                  input ready);
  modport sink   (input valid, input quantity, input record_tag, input is_last,
                  output ready);
endinterface

interface rxs_out_if;
  import rxs_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [RXS_KEY_W-1:0] sorted_quantity;
  logic [RXS_TAG_W-1:0] sorted_tag;
  logic                 last_out;
  logic                 dropped;

  modport source (output valid, output sorted_quantity, output sorted_tag,
                  output last_out, output dropped, input ready);
  modport sink   (input valid, input sorted_quantity, input sorted_tag,
                  input last_out, input dropped, output ready);
endinterface

>>> hdl/rxs_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read.
// Stand-alone; no package dependency.
module rxs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/rxs_ctrl.sv
// Controller of the record exchange sort block: load, sort and emit sequencing.
// Depends on rxs_pkg for the command and status structs.
module rxs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_is_last,
  output logic          in_ready,
  input  rxs_pkg::sts_t sts,
  output rxs_pkg::cmd_t cmd
);
  import rxs_pkg::*;

  typedef enum logic [3:0] {
    IDLE, START, SORT_RI, SORT_LI, SORT_RJ, SORT_CJ, SORT_WI, EMIT_RD, EMIT_LD
  } state_t;

  state_t state_r, state_nxt;
  logic   in_fire;

  assign in_ready = (state_r == IDLE);
  assign in_fire  = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      IDLE: begin
        cmd.load = in_fire;
        if (in_fire && in_is_last) begin
          state_nxt = START;
        end
      end
      START: begin
        if (sts.n_lt2) begin
          cmd.init_emit = 1'b1;
          state_nxt     = EMIT_RD;
        end else begin
          cmd.init_sort = 1'b1;
          state_nxt     = SORT_RI;
        end
      end
      SORT_RI: begin
        cmd.rd_i  = 1'b1;
        state_nxt = SORT_LI;
      end
      SORT_LI: begin
        cmd.cap_held = 1'b1;
        state_nxt    = SORT_RJ;
      end
      SORT_RJ: begin
        cmd.rd_j  = 1'b1;
        state_nxt = SORT_CJ;
      end
      SORT_CJ: begin
        cmd.cmp_j = 1'b1;
        state_nxt = sts.j_last ? SORT_WI : SORT_RJ;
      end
      SORT_WI: begin
        cmd.wr_i = 1'b1;
        if (sts.i_last) begin
          cmd.init_emit = 1'b1;
          state_nxt     = EMIT_RD;
        end else begin
          state_nxt = SORT_RI;
        end
      end
      EMIT_RD: begin
        cmd.rd_k  = 1'b1;
        state_nxt = EMIT_LD;
      end
      EMIT_LD: begin
        if (sts.out_free) begin
          cmd.ld_out = 1'b1;
          if (sts.k_last) begin
            cmd.clr_set = 1'b1;
            state_nxt   = IDLE;
          end else begin
            state_nxt = EMIT_RD;
          end
        end
      end
      default: state_nxt = IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/rxs_dp.sv
// Datapath of the record exchange sort block: record RAM, counters, held record
// and output register. Depends on rxs_pkg and rxs_ram.
module rxs_dp #(
  parameter int MAX_RECORDS = rxs_pkg::RXS_MAX_RECORDS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  rxs_pkg::cmd_t                 cmd,
  output rxs_pkg::sts_t                 sts,
  input  rxs_pkg::rec_t                 in_rec,
  input  logic                          out_ready,
  output logic                          out_valid,
  output logic [rxs_pkg::RXS_KEY_W-1:0] out_quantity,
  output logic [rxs_pkg::RXS_TAG_W-1:0] out_tag,
  output logic                          out_last,
  output logic                          out_dropped
);
  import rxs_pkg::*;

  localparam int AW = $clog2(MAX_RECORDS);
  localparam int CW = $clog2(MAX_RECORDS + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [CW-1:0] i_r, i_nxt, j_r, j_nxt, k_r, k_nxt;
  rec_t          held_r, held_nxt;
  logic          oval_r, oval_nxt;
  rec_t          orec_r, orec_nxt;
  logic          olast_r, olast_nxt, odrop_r, odrop_nxt;

  logic          we, re;
  logic [AW-1:0] waddr, raddr;
  rec_t          wdata, rdata;
  logic          store_full, swap;

  assign store_full = (count_r == CW'(MAX_RECORDS));
  assign swap       = cmd.cmp_j && (held_r.key > rdata.key);

  // Write port: load, swap into j, or held record back into i
  always_comb begin
    we    = 1'b0;
    waddr = i_r[AW-1:0];
    wdata = held_r;
    if (cmd.load && !store_full) begin
      we    = 1'b1;
      waddr = count_r[AW-1:0];
      wdata = in_rec;
    end else if (swap) begin
      we    = 1'b1;
      waddr = j_r[AW-1:0];
    end else if (cmd.wr_i) begin
      we = 1'b1;
    end
  end

  // Read port
  always_comb begin
    re    = cmd.rd_i || cmd.rd_j || cmd.rd_k;
    raddr = k_r[AW-1:0];
    if (cmd.rd_i) begin
      raddr = i_r[AW-1:0];
    end else if (cmd.rd_j) begin
      raddr = j_r[AW-1:0];
    end
  end

  rxs_ram #(.WIDTH(RXS_REC_W), .DEPTH(MAX_RECORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    count_nxt = count_r;
    ovf_nxt   = ovf_r;
    i_nxt     = i_r;
    j_nxt     = j_r;
    k_nxt     = k_r;
    held_nxt  = held_r;
    oval_nxt  = oval_r && !out_ready;
    orec_nxt  = orec_r;
    olast_nxt = olast_r;
    odrop_nxt = odrop_r;
    if (cmd.load) begin
      if (store_full) begin
        ovf_nxt = 1'b1;
      end else begin
        count_nxt = count_r + CW'(1);
      end
    end
    if (cmd.init_sort) begin
      i_nxt = '0;
    end
    if (cmd.rd_i) begin
      j_nxt = i_r + CW'(1);
    end
    if (cmd.cap_held || swap) begin
      held_nxt = rdata;
    end
    if (cmd.cmp_j) begin
      j_nxt = j_r + CW'(1);
    end
    if (cmd.wr_i) begin
      i_nxt = i_r + CW'(1);
    end
    if (cmd.init_emit) begin
      k_nxt = '0;
    end
    if (cmd.ld_out) begin
      oval_nxt  = 1'b1;
      orec_nxt  = rdata;
      olast_nxt = sts.k_last;
      odrop_nxt = ovf_r;
      k_nxt     = k_r + CW'(1);
    end
    if (cmd.clr_set) begin
      count_nxt = '0;
      ovf_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      ovf_r   <= 1'b0;
      oval_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      ovf_r   <= ovf_nxt;
      oval_r  <= oval_nxt;
    end
    i_r     <= i_nxt;
    j_r     <= j_nxt;
    k_r     <= k_nxt;
    held_r  <= held_nxt;
    orec_r  <= orec_nxt;
    olast_r <= olast_nxt;
    odrop_r <= odrop_nxt;
  end

  assign sts.n_lt2    = (count_r < CW'(2));
  assign sts.j_last   = (j_r + CW'(1) == count_r);
  assign sts.i_last   = (i_r + CW'(2) == count_r);
  assign sts.k_last   = (k_r + CW'(1) == count_r);
  assign sts.out_free = !oval_r || out_ready;

  assign out_valid    = oval_r;
  assign out_quantity = orec_r.key;
  assign out_tag      = orec_r.tag;
  assign out_last     = olast_r;
  assign out_dropped  = odrop_r;

endmodule

>>> hdl/record_exchange_sort_core.sv
// Record exchange sort core: loads a set of records, sorts ascending by key, emits.
// Sequence: loading accepts transactions while the core is idle; after the last one
//   it sorts n >= 2 records by exchange (a single record skips the sort), then emits
//   each result by a RAM read and an output register load, waiting while output stalls.
// Throughput: one set at a time; the single read port of the record RAM sets the pace.
// Reset: synchronous active-low rst_n empties the store and drops any pending result.
module record_exchange_sort_core #(
  parameter int MAX_RECORDS = rxs_pkg::RXS_MAX_RECORDS
) (
  input  logic           clk,
  input  logic           rst_n,
  rxs_in_if.sink         in_chan,
  rxs_out_if.source      out_chan
);
  import rxs_pkg::*;

  cmd_t cmd;
  sts_t sts;
  rec_t in_rec;

  // Pack the incoming transaction into a record for the RAM write port
  assign in_rec.key = in_chan.quantity;
  assign in_rec.tag = in_chan.record_tag;

  // Controller: accept input only while loading, sequence sort and emission
  rxs_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_is_last (in_chan.is_last),
    .in_ready   (in_chan.ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  // Datapath: the record store, the held record of the outer pass, and the
  // output register that decouples the result channel from the sequencing
  rxs_dp #(.MAX_RECORDS(MAX_RECORDS)) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .sts          (sts),
    .in_rec       (in_rec),
    .out_ready    (out_chan.ready),
    .out_valid    (out_chan.valid),
    .out_quantity (out_chan.sorted_quantity),
    .out_tag      (out_chan.sorted_tag),
    .out_last     (out_chan.last_out),
    .out_dropped  (out_chan.dropped)
  );

endmodule

>>> tb/sv/rxs_sort_checker.sv
// Checker for the record exchange sort core: predicts the sorted output of each set.
// Watches the input and result channels; depends on rxs_pkg and the rxs_in_if and
// rxs_out_if interfaces.
`timescale 1ns / 1ps

module rxs_sort_checker #(
  parameter int MAX_RECORDS = rxs_pkg::RXS_MAX_RECORDS
) (
  input  logic        clk,
  input  logic        rst_n,
  rxs_in_if           in_mon,
  rxs_out_if          out_mon,
  output int unsigned fail_count,
  output int unsigned awaited
);
  import rxs_pkg::*;

  typedef struct {
    logic [RXS_KEY_W-1:0] quantity;
    logic [RXS_TAG_W-1:0] tag;
    logic                 last;
    logic                 dropped;
  } sorted_rec_t;

  rec_t        held_recs [MAX_RECORDS];
  int unsigned held_count;
  bit          overflow;
  sorted_rec_t sorted_q [$];
  int unsigned fails;

  task automatic report_mismatch(input string msg);
    if (fails < 100) $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  // Sort the held records in place: compare each position with every later one.
  task automatic sort_held();
    rec_t tmp;
    for (int i = 0; i < int'(held_count); i++) begin
      for (int j = i + 1; j < int'(held_count); j++) begin
        if (held_recs[i].key > held_recs[j].key) begin
          tmp          = held_recs[i];
          held_recs[i] = held_recs[j];
          held_recs[j] = tmp;
        end
      end
    end
  endtask

  task automatic take_record(input logic [RXS_KEY_W-1:0] qty,
                             input logic [RXS_TAG_W-1:0] tag, input logic last);
    sorted_rec_t res;
    if (held_count < MAX_RECORDS) begin
      held_recs[held_count].key = qty;
      held_recs[held_count].tag = tag;
      held_count++;
    end else begin
      overflow = 1'b1;
    end
    if (last) begin
      sort_held();
      for (int k = 0; k < int'(held_count); k++) begin
        res.quantity = held_recs[k].key;
        res.tag      = held_recs[k].tag;
        res.last     = (k + 1 == int'(held_count));
        res.dropped  = overflow;
        sorted_q.push_back(res);
      end
      held_count = 0;
      overflow   = 1'b0;
    end
  endtask

  task automatic check_result();
    sorted_rec_t want;
    if (sorted_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result qty=%h tag=%h last=%b dropped=%b",
                                out_mon.sorted_quantity, out_mon.sorted_tag,
                                out_mon.last_out, out_mon.dropped));
    end else begin
      want = sorted_q.pop_front();
      if (out_mon.sorted_quantity !== want.quantity || out_mon.sorted_tag !== want.tag ||
          out_mon.last_out !== want.last || out_mon.dropped !== want.dropped)
        report_mismatch($sformatf(
          "got qty=%h tag=%h last=%b dropped=%b, want qty=%h tag=%h last=%b dropped=%b",
          out_mon.sorted_quantity, out_mon.sorted_tag, out_mon.last_out, out_mon.dropped,
          want.quantity, want.tag, want.last, want.dropped));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      held_count = 0;
      overflow   = 1'b0;
      sorted_q.delete();
    end else begin
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1)
        take_record(in_mon.quantity, in_mon.record_tag, in_mon.is_last);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1)
        check_result();
    end
    fail_count <= fails;
    awaited    <= sorted_q.size();
  end

endmodule

>>> tb/sv/testbench.sv
// Top of the record exchange sort testbench: clock, reset, stimulus and the verdict.
// Instantiates record_exchange_sort_core beside rxs_sort_checker; depends on rxs_pkg
// and the channel interfaces.
`timescale 1ns / 1ps

module testbench;
  import rxs_pkg::*;

  // Generous bound on the whole run, in clock cycles
  localparam int unsigned CYCLE_LIMIT = 600000;
  // Longest busy stretch of the core: a full sort plus emission
  localparam int unsigned DRAIN_CYCLES = RXS_MAX_RECORDS * RXS_MAX_RECORDS + 4 * RXS_MAX_RECORDS;
  localparam int PHASE_ITEMS = 36;

  // Key patterns for random sets
  typedef enum int {KEYS_ANY, KEYS_CROWDED, KEYS_EXTREME} key_mode_t;

  logic        clk;
  logic        rst_n;
  int unsigned cycle_count;
  int unsigned fail_count;
  int unsigned awaited;
  int          idle_pct;
  int          stall_pct;
  int          phase_items;

  rxs_in_if  in_chan ();
  rxs_out_if out_chan ();

  record_exchange_sort_core i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  rxs_sort_checker i_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_chan),
    .out_mon    (out_chan),
    .fail_count (fail_count),
    .awaited    (awaited)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Stall the result channel at random.
  always @(posedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Bound the run: a hang ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench failed");
      $finish;
    end
  end

  function automatic logic [RXS_KEY_W-1:0] pick_quantity(input key_mode_t mode);
    case (mode)
      KEYS_CROWDED: pick_quantity = RXS_KEY_W'($urandom_range(3));
      KEYS_EXTREME: begin
        case ($urandom_range(2))
          0:       pick_quantity = '0;
          1:       pick_quantity = '1;
          default: pick_quantity = RXS_KEY_W'($urandom);
        endcase
      end
      default: pick_quantity = RXS_KEY_W'($urandom);
    endcase
  endfunction

  // Offer one record and hold it until the core takes the transaction.
  // Leave valid high on return so back-to-back records need no second assignment.
  task automatic send_record(input logic [RXS_KEY_W-1:0] qty,
                             input logic [RXS_TAG_W-1:0] tag, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid      <= 1'b1;
    in_chan.quantity   <= qty;
    in_chan.record_tag <= tag;
    in_chan.is_last    <= last;
    @(posedge clk);
    while (in_chan.ready !== 1'b1) @(posedge clk);
    phase_items++;
  endtask

  task automatic send_set(input int count, input key_mode_t mode);
    for (int idx = 0; idx < count; idx++)
      send_record(pick_quantity(mode), RXS_TAG_W'($urandom), idx == count - 1);
  endtask

  // Pick a set size: mostly small, a few near capacity, rarely beyond it.
  function automatic int pick_set_size();
    int r;
    r = $urandom_range(99);
    if (r < 70)      pick_set_size = $urandom_range(8, 1);
    else if (r < 90) pick_set_size = $urandom_range(24, 9);
    else if (r < 97) pick_set_size = $urandom_range(RXS_MAX_RECORDS, 25);
    else             pick_set_size = $urandom_range(RXS_MAX_RECORDS + 6, RXS_MAX_RECORDS + 1);
  endfunction

  initial begin
    // Drive reset and every input channel signal to a known value before the first edge.
    rst_n              <= 1'b0;
    in_chan.valid      <= 1'b0;
    in_chan.quantity   <= '0;
    in_chan.record_tag <= '0;
    in_chan.is_last    <= 1'b0;
    idle_pct    = 0;
    stall_pct   = 0;
    phase_items = 0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed sets with no idling.
    // Single record with the top key and a zero tag.
    send_record('1, '0, 1'b1);
    // Two records in reverse order, extremes of key and tag.
    send_record('1, '1, 1'b0);
    send_record('0, 16'h0001, 1'b1);
    // Equal keys around a smaller one: the swap order decides their placement.
    send_record(16'h1234, 16'h0001, 1'b0);
    send_record(16'h1234, 16'h0002, 1'b0);
    send_record(16'h0100, 16'h0003, 1'b0);
    send_record(16'h1234, 16'h0004, 1'b0);
    send_record(16'h1234, 16'h0005, 1'b1);
    // Already ascending.
    send_record(16'h0001, 16'hAAAA, 1'b0);
    send_record(16'h8000, 16'h5555, 1'b0);
    send_record(16'hFFFE, 16'hFFFF, 1'b1);
    // Overfill the store: the marked final record itself is discarded.
    send_set(RXS_MAX_RECORDS + 1, KEYS_EXTREME);
    // A plain set right after an overflowed one must come back with the flag clear.
    send_record(16'h0002, 16'h0010, 1'b0);
    send_record(16'h0001, 16'h0020, 1'b1);

    // Random sets, one idling pattern per phase.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin idle_pct = 0;  stall_pct = 0;  end
        1:       begin idle_pct = 63; stall_pct = 0;  end
        2:       begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 31; stall_pct = 31; end
      endcase
      phase_items = 0;
      while (phase_items < PHASE_ITEMS)
        send_set(pick_set_size(), key_mode_t'($urandom_range(2)));
    end
    in_chan.valid <= 1'b0;

    // Drain: let the checker see the last transaction, then every expected result.
    @(posedge clk);
    while (awaited != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_count == 0 && awaited == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/rxs_pkg.sv
hdl/rxs_if.sv
hdl/rxs_ram.sv
hdl/rxs_ctrl.sv
hdl/rxs_dp.sv
hdl/record_exchange_sort_core.sv
tb/sv/rxs_sort_checker.sv
tb/sv/testbench.sv
